@@ rtl/srrw_pkg.sv @@
// Shared types, field widths and register codes of the selective-repeat
// receive window. No dependencies.
`timescale 1ns / 1ps

package srrw_pkg;

   // Default sizing, handed to the top level parameters
   localparam int WINDOW_MAX_DEF       = 128;
   localparam int FRAMES_MAX_DEF       = 1024;
   localparam int FRAME_DATA_BYTES_DEF = 1024;

   // Fixed field widths
   localparam int SEQ_W    = 10;
   localparam int PAY_W    = 11;
   localparam int OFFSET_W = 20;
   localparam int LENGTH_W = 21;
   localparam int WREG_W   = 8;
   localparam int FREG_W   = 11;
   localparam int EXP_W    = 11;   // frame count, holds seq + 1 and the clamped register
   localparam int NEXT_W   = 11;   // next expected sequence, 0 .. 1024

   // Register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_WINDOW = 1'b0;
   localparam logic REG_FRAMES = 1'b1;

   localparam logic [WREG_W-1:0] WINDOW_RESET = 8'd100;
   localparam logic [FREG_W-1:0] FRAMES_RESET = 11'd1000;

   typedef struct packed {
      logic [SEQ_W-1:0] seq_number;
      logic             frame_bad;
      logic             end_of_transfer;
      logic [PAY_W-1:0] payload_bytes;
   } req_item_type;

   typedef struct packed {
      logic [SEQ_W-1:0]    ack_number;
      logic                ack_negative;
      logic                store_payload;
      logic [OFFSET_W-1:0] store_offset;
      logic                buffer_complete;
      logic [LENGTH_W-1:0] buffer_length;
      logic                transfer_done;
   } rsp_item_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic commit;
   } ctrl_cmd_type;

   // Controller to channel handshake
   typedef struct packed {
      logic req_ready;
      logic rsp_valid;
   } hs_type;

endpackage

@@ rtl/srrw_req_if.sv @@
// Input channel: one frame header per transfer.
// Depends on srrw_pkg for the field widths.
`timescale 1ns / 1ps

interface srrw_req_if;
   import srrw_pkg::*;

   logic             valid;
   logic             ready;
   logic [SEQ_W-1:0] seq_number;
   logic             frame_bad;
   logic             end_of_transfer;
   logic [PAY_W-1:0] payload_bytes;

   modport source (output valid, seq_number, frame_bad, end_of_transfer, payload_bytes,
                   input ready);
   modport sink   (input valid, seq_number, frame_bad, end_of_transfer, payload_bytes,
                   output ready);
endinterface

@@ rtl/srrw_rsp_if.sv @@
// Result channel: one acknowledgement and store decision per transfer.
// Depends on srrw_pkg for the field widths.
`timescale 1ns / 1ps

interface srrw_rsp_if;
   import srrw_pkg::*;

   logic                valid;
   logic                ready;
   logic [SEQ_W-1:0]    ack_number;
   logic                ack_negative;
   logic                store_payload;
   logic [OFFSET_W-1:0] store_offset;
   logic                buffer_complete;
   logic [LENGTH_W-1:0] buffer_length;
   logic                transfer_done;

   modport source (output valid, ack_number, ack_negative, store_payload, store_offset,
                   buffer_complete, buffer_length, transfer_done,
                   input ready);
   modport sink   (input valid, ack_number, ack_negative, store_payload, store_offset,
                   buffer_complete, buffer_length, transfer_done,
                   output ready);
endinterface

@@ rtl/srrw_csr.sv @@
// Configuration registers behind the APB-style port, with clamped values.
// Depends on srrw_pkg.
`timescale 1ns / 1ps

module srrw_csr #(
   parameter int WINDOW_MAX = srrw_pkg::WINDOW_MAX_DEF,
   parameter int FRAMES_MAX = srrw_pkg::FRAMES_MAX_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [srrw_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [srrw_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [srrw_pkg::CSR_DATA_W-1:0]  prdata,
   output logic [$clog2(WINDOW_MAX+1)-1:0]  win_eff,
   output logic [srrw_pkg::EXP_W-1:0]       frames_eff,
   output logic                             frames_load
);
   import srrw_pkg::*;

   localparam int WIN_W = $clog2(WINDOW_MAX + 1);

   logic [WREG_W-1:0] window_ff, window_in;
   logic [FREG_W-1:0] frames_ff, frames_in;
   logic              wr_strobe;
   logic              reg_sel;

   assign wr_strobe = psel && penable && pwrite;
   assign reg_sel   = paddr[2];

   // Decode the write transfer
   always_comb begin
      window_in   = window_ff;
      frames_in   = frames_ff;
      frames_load = 1'b0;
      if (wr_strobe) begin
         case (reg_sel)
            REG_WINDOW: window_in = pwdata[WREG_W-1:0];
            REG_FRAMES: begin
               frames_in   = pwdata[FREG_W-1:0];
               frames_load = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         frames_ff <= FRAMES_RESET;
      end else begin
         window_ff <= window_in;
         frames_ff <= frames_in;
      end
   end

   // Read back the raw register values
   always_comb begin
      case (reg_sel)
         REG_WINDOW: prdata = CSR_DATA_W'(window_ff);
         REG_FRAMES: prdata = CSR_DATA_W'(frames_ff);
         default:    prdata = '0;
      endcase
   end

   // Clamp the window to 1 .. WINDOW_MAX
   always_comb begin
      if (window_ff == '0)
         win_eff = WIN_W'(1);
      else if (32'(window_ff) > WINDOW_MAX)
         win_eff = WIN_W'(WINDOW_MAX);
      else
         win_eff = WIN_W'(window_ff);
   end

   // Clamp the frame count to 1 .. FRAMES_MAX; follows the value being written
   always_comb begin
      if (frames_in == '0)
         frames_eff = EXP_W'(1);
      else if (32'(frames_in) > FRAMES_MAX)
         frames_eff = EXP_W'(FRAMES_MAX);
      else
         frames_eff = EXP_W'(frames_in);
   end

endmodule

@@ rtl/srrw_ctrl.sv @@
// Controller: sequences capture and commit of one frame header and owns
// the result valid flag. Depends on srrw_pkg.
`timescale 1ns / 1ps

module srrw_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   rsp_ready,
   output srrw_pkg::ctrl_cmd_type cmd,
   output srrw_pkg::hs_type       hs
);
   import srrw_pkg::*;

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_SLIDE = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign hs.req_ready = (state_ff == ST_IDLE);
   assign hs.rsp_valid = rsp_valid_ff;
   assign cmd.capture  = (state_ff == ST_IDLE) && req_valid;
   assign cmd.commit   = (state_ff == ST_SLIDE) && out_free;

   // Advance on capture, hold in slide until the output register frees up
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_SLIDE;
         ST_SLIDE: if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Load the result on commit, drop it once transferred
   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/srrw_datapath.sv @@
// Datapath: window state, mark bitmap, grouped first-zero search, slide
// and result register. Depends on srrw_pkg.
`timescale 1ns / 1ps

module srrw_datapath #(
   parameter int WINDOW_MAX       = srrw_pkg::WINDOW_MAX_DEF,
   parameter int FRAMES_MAX       = srrw_pkg::FRAMES_MAX_DEF,
   parameter int FRAME_DATA_BYTES = srrw_pkg::FRAME_DATA_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  srrw_pkg::ctrl_cmd_type          cmd,
   input  srrw_pkg::req_item_type          req_item,
   input  logic [$clog2(WINDOW_MAX+1)-1:0] win_eff,
   input  logic [srrw_pkg::EXP_W-1:0]      frames_eff,
   input  logic                            frames_load,
   output srrw_pkg::rsp_item_type          rsp_item
);
   import srrw_pkg::*;

   localparam int WIN_W  = $clog2(WINDOW_MAX + 1);
   localparam int IDX_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int GRP    = 16;
   localparam int POS_W  = $clog2(GRP);
   localparam int NG     = WINDOW_MAX / GRP + 1;
   localparam int PAD_W  = NG * GRP;
   localparam int CMP_W  = ((NEXT_W > WIN_W) ? NEXT_W : WIN_W) + 1;
   localparam int FDB_W  = $clog2(FRAME_DATA_BYTES + 1);
   localparam int PAYC_W = (PAY_W > FDB_W) ? PAY_W : FDB_W;
   localparam int PROD_W = EXP_W + FDB_W;
   localparam int EXP_RESET = (32'(FRAMES_RESET) > FRAMES_MAX) ? FRAMES_MAX
                                                                : 32'(FRAMES_RESET);
   localparam logic [LENGTH_W-1:0] FINAL_RESET = LENGTH_W'(EXP_RESET * FRAME_DATA_BYTES);

   // Window state
   logic [WINDOW_MAX-1:0] marks_ff, marks_in;
   logic [NEXT_W-1:0]     next_ff, next_in;
   logic [EXP_W-1:0]      expected_ff, expected_in;
   logic [LENGTH_W-1:0]   final_ff, final_in;
   logic                  ending_ff, ending_in;
   logic                  finished_ff, finished_in;

   // Captured header and search results
   req_item_type          item_ff;
   logic                  head_ff;
   logic                  newmark_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic [NG-1:0]         grp_zero_ff;
   logic [NG-1:0][POS_W-1:0] grp_pos_ff;

   // Capture-side logic
   logic [CMP_W-1:0]      seq_x, next_x, win_x, exp_x, diff_x;
   logic                  in_win;
   logic [IDX_W-1:0]      idx_c;
   logic                  head_c, newmark_c;
   logic [PAD_W-1:0]      marks_pad, masked;
   logic [NG-1:0]         grp_zero_c;
   logic [NG-1:0][POS_W-1:0] grp_pos_c;

   // Commit-side logic
   logic [WIN_W-1:0]      shift;
   logic [NEXT_W:0]       next_sum;
   logic [NEXT_W-1:0]     next_step;
   logic [WINDOW_MAX-1:0] marks_step;
   logic                  accepted, take_end;
   logic [PAYC_W-1:0]     pay_c;
   logic [PROD_W-1:0]     seq_prod;
   logic [EXP_W-1:0]      exp_step;
   logic [LENGTH_W-1:0]   final_step, final_load;
   logic                  ending_step;
   logic                  complete;

   // Window test on the incoming header
   always_comb begin
      seq_x  = CMP_W'(req_item.seq_number);
      next_x = CMP_W'(next_ff);
      win_x  = CMP_W'(win_eff);
      exp_x  = CMP_W'(expected_ff);
      diff_x = seq_x - next_x;
      idx_c  = diff_x[IDX_W-1:0];
      in_win = !req_item.frame_bad && (seq_x >= next_x) && (seq_x < next_x + win_x)
               && (seq_x < exp_x);
      head_c    = in_win && (diff_x == '0);
      newmark_c = in_win && (diff_x != '0) && !marks_ff[idx_c];
   end

   // Mask the bitmap to the window, force the head, search each group
   always_comb begin
      marks_pad = PAD_W'(marks_ff);
      for (int i = 0; i < PAD_W; i++) begin
         masked[i] = (i == 0) || (marks_pad[i] && (32'(i) < 32'(win_eff)));
      end
      for (int g = 0; g < NG; g++) begin
         grp_zero_c[g] = !(&masked[g*GRP +: GRP]);
         grp_pos_c[g]  = '0;
         for (int k = GRP - 1; k >= 0; k--) begin
            if (!masked[g*GRP + k]) grp_pos_c[g] = POS_W'(k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff     <= req_item;
         head_ff     <= head_c;
         newmark_ff  <= newmark_c;
         idx_ff      <= idx_c;
         grp_zero_ff <= grp_zero_c;
         grp_pos_ff  <= grp_pos_c;
      end
   end

   // Merge the groups into the slide distance
   always_comb begin
      shift = WIN_W'(WINDOW_MAX);
      for (int g = NG - 1; g >= 0; g--) begin
         if (grp_zero_ff[g]) shift = WIN_W'(g * GRP + 32'(grp_pos_ff[g]));
      end
   end

   // Slide or mark, then apply end-of-transfer and the completion check
   always_comb begin
      accepted   = head_ff || newmark_ff;
      next_sum   = (NEXT_W+1)'(next_ff) + (NEXT_W+1)'(head_ff ? shift : '0);
      next_step  = next_sum[NEXT_W-1:0];
      if (head_ff)
         marks_step = marks_ff >> shift;
      else if (newmark_ff)
         marks_step = marks_ff | (WINDOW_MAX'(1) << idx_ff);
      else
         marks_step = marks_ff;

      if (32'(item_ff.payload_bytes) > FRAME_DATA_BYTES)
         pay_c = PAYC_W'(FRAME_DATA_BYTES);
      else
         pay_c = PAYC_W'(item_ff.payload_bytes);
      seq_prod = PROD_W'(item_ff.seq_number) * PROD_W'(FRAME_DATA_BYTES);

      take_end    = accepted && item_ff.end_of_transfer;
      exp_step    = take_end ? EXP_W'(item_ff.seq_number) + EXP_W'(1) : expected_ff;
      final_step  = take_end ? LENGTH_W'(seq_prod + PROD_W'(pay_c)) : final_ff;
      ending_step = take_end || ending_ff;
      complete    = !finished_ff && (next_step >= exp_step);

      final_load = LENGTH_W'(PROD_W'(frames_eff) * PROD_W'(FRAME_DATA_BYTES));
   end

   // Next state of the window
   always_comb begin
      marks_in    = marks_ff;
      next_in     = next_ff;
      expected_in = expected_ff;
      final_in    = final_ff;
      ending_in   = ending_ff;
      finished_in = finished_ff;
      if (cmd.commit && !finished_ff) begin
         if (complete) begin
            marks_in    = '0;
            next_in     = '0;
            expected_in = frames_eff;
            final_in    = final_load;
            ending_in   = 1'b0;
            finished_in = ending_step;
         end else begin
            marks_in    = marks_step;
            next_in     = next_step;
            expected_in = exp_step;
            final_in    = final_step;
            ending_in   = ending_step;
         end
      end else if (frames_load && !ending_ff) begin
         expected_in = frames_eff;
         final_in    = final_load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         marks_ff    <= '0;
         next_ff     <= '0;
         expected_ff <= EXP_W'(EXP_RESET);
         final_ff    <= FINAL_RESET;
         ending_ff   <= 1'b0;
         finished_ff <= 1'b0;
      end else begin
         marks_ff    <= marks_in;
         next_ff     <= next_in;
         expected_ff <= expected_in;
         final_ff    <= final_in;
         ending_ff   <= ending_in;
         finished_ff <= finished_in;
      end
   end

   // Load the result register on commit
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_item.ack_number      <= item_ff.seq_number;
         rsp_item.ack_negative    <= item_ff.frame_bad;
         rsp_item.store_payload   <= !finished_ff && accepted;
         rsp_item.store_offset    <= (!finished_ff && accepted) ? OFFSET_W'(seq_prod) : '0;
         rsp_item.buffer_complete <= complete;
         rsp_item.buffer_length   <= complete ? final_step : '0;
         rsp_item.transfer_done   <= finished_ff || (complete && ending_step);
      end
   end

endmodule

@@ rtl/selective_repeat_receive_window_unit.sv @@
// Top level of the selective-repeat receive window: controller, datapath
// and register file. Depends on srrw_pkg, srrw_req_if, srrw_rsp_if.
//
//   channel  direction  transfer unit
//   req_ch   in         one received frame header
//   rsp_ch   out        one acknowledgement with store and completion flags
//   APB      in/out     window_length at 0x0, frames_per_buffer at 0x4
//
// Each header is handled in a capture step and a commit step: capture runs
// the per-group first-zero search over the mark bitmap, commit merges the
// groups, slides the bitmap and updates the window state.
// The result register lets the next header be captured while a result waits;
// commit holds while the previous result has not been taken.
// Reset is synchronous and clears the bitmap flip-flops.
`timescale 1ns / 1ps

module selective_repeat_receive_window_unit #(
   parameter int WINDOW_MAX       = srrw_pkg::WINDOW_MAX_DEF,
   parameter int FRAMES_MAX       = srrw_pkg::FRAMES_MAX_DEF,
   parameter int FRAME_DATA_BYTES = srrw_pkg::FRAME_DATA_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   srrw_req_if.sink                        req_ch,
   srrw_rsp_if.source                      rsp_ch,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [srrw_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [srrw_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [srrw_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import srrw_pkg::*;

   ctrl_cmd_type                    cmd;
   hs_type                          hs;
   req_item_type                    req_item;
   rsp_item_type                    rsp_item;
   logic [$clog2(WINDOW_MAX+1)-1:0] win_eff;
   logic [EXP_W-1:0]                frames_eff;
   logic                            frames_load;

   assign pready = 1'b1;

   // Bundle the input channel payload
   assign req_item.seq_number      = req_ch.seq_number;
   assign req_item.frame_bad       = req_ch.frame_bad;
   assign req_item.end_of_transfer = req_ch.end_of_transfer;
   assign req_item.payload_bytes   = req_ch.payload_bytes;
   assign req_ch.ready             = hs.req_ready;

   // Drive the result channel
   assign rsp_ch.valid           = hs.rsp_valid;
   assign rsp_ch.ack_number      = rsp_item.ack_number;
   assign rsp_ch.ack_negative    = rsp_item.ack_negative;
   assign rsp_ch.store_payload   = rsp_item.store_payload;
   assign rsp_ch.store_offset    = rsp_item.store_offset;
   assign rsp_ch.buffer_complete = rsp_item.buffer_complete;
   assign rsp_ch.buffer_length   = rsp_item.buffer_length;
   assign rsp_ch.transfer_done   = rsp_item.transfer_done;

   srrw_csr #(
      .WINDOW_MAX (WINDOW_MAX),
      .FRAMES_MAX (FRAMES_MAX)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .win_eff     (win_eff),
      .frames_eff  (frames_eff),
      .frames_load (frames_load)
   );

   srrw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .hs        (hs)
   );

   srrw_datapath #(
      .WINDOW_MAX       (WINDOW_MAX),
      .FRAMES_MAX       (FRAMES_MAX),
      .FRAME_DATA_BYTES (FRAME_DATA_BYTES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_item    (req_item),
      .win_eff     (win_eff),
      .frames_eff  (frames_eff),
      .frames_load (frames_load),
      .rsp_item    (rsp_item)
   );

endmodule
